FILE: design/alarm_clock_set_and_ring_defines.svh
// assertion macros shared by the alarm clock rtl
`ifndef ALARM_CLOCK_SET_AND_RING_DEFINES_SVH
`define ALARM_CLOCK_SET_AND_RING_DEFINES_SVH

// consequent checked on the same edge as the antecedent
`define ACSR_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("acsr: same-cycle check failed");

// consequent checked on the edge after the antecedent
`define ACSR_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("acsr: next-cycle check failed");

`endif

FILE: design/acsr_pkg.sv
// types and constants for the alarm clock set and ring block
package acsr_pkg;

  localparam int unsigned HOUR_W     = 5;
  localparam int unsigned MINUTE_W   = 6;
  localparam int unsigned HOLD_W     = 16;
  localparam int unsigned RING_W     = 24;
  localparam int unsigned CFG_DATA_W = 24;

  localparam logic [HOUR_W-1:0]   LAST_HOUR   = HOUR_W'(23);
  localparam logic [MINUTE_W-1:0] LAST_MINUTE = MINUTE_W'(59);
  localparam logic [HOUR_W-1:0]   HOURS_PER_DAY    = HOUR_W'(24);
  localparam logic [MINUTE_W-1:0] MINUTES_PER_HOUR = MINUTE_W'(60);

  localparam logic [HOLD_W-1:0] HOLD_MAX = '1;
  localparam logic [RING_W-1:0] RING_MAX = '1;

  localparam logic [HOLD_W-1:0]   LONG_PRESS_RESET    = HOLD_W'(1000);
  localparam logic [RING_W-1:0]   RING_DURATION_RESET = RING_W'(60000);
  localparam logic [HOUR_W-1:0]   ALARM_HOUR_RESET    = HOUR_W'(7);
  localparam logic [MINUTE_W-1:0] ALARM_MINUTE_RESET  = MINUTE_W'(30);
  localparam logic                ALARM_ON_RESET      = 1'b1;

  typedef enum logic [0:0] {
    CFG_LONG_PRESS    = 1'b0,
    CFG_RING_DURATION = 1'b1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    FIELD_HOUR   = 2'd0,
    FIELD_MINUTE = 2'd1,
    FIELD_ON     = 2'd2,
    FIELD_SAVE   = 2'd3
  } field_t;

  typedef struct packed {
    logic                set_button_down;
    logic                stop_button_down;
    logic                time_valid;
    logic [HOUR_W-1:0]   now_hour;
    logic [MINUTE_W-1:0] now_minute;
  } in_t;

  typedef struct packed {
    logic                ringing;
    logic                setting_active;
    logic [1:0]          selected_field;
    logic [HOUR_W-1:0]   draft_hour;
    logic [MINUTE_W-1:0] draft_minute;
    logic                draft_on;
    logic [HOUR_W-1:0]   saved_hour;
    logic [MINUTE_W-1:0] saved_minute;
    logic                saved_on;
  } out_t;

  typedef struct packed {
    logic [HOUR_W-1:0]   hour;
    logic [MINUTE_W-1:0] minute;
    logic                enabled;
  } alarm_t;

  typedef struct packed {
    logic                mode;
    field_t              field;
    logic [HOUR_W-1:0]   hour;
    logic [MINUTE_W-1:0] minute;
    logic                enabled;
  } draft_t;

endpackage

FILE: design/acsr_ring.sv
// alarm match, ring timeout and stop logic
`include "alarm_clock_set_and_ring_defines.svh"

module acsr_ring (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             en,
  input  acsr_pkg::in_t                    tick,
  input  acsr_pkg::alarm_t                 alarm,
  input  logic [acsr_pkg::RING_W-1:0]      ring_duration_ticks,
  output logic                             ringing_next
);

  logic                        ring_flag;
  logic [acsr_pkg::RING_W-1:0] ring_elapsed;
  logic [acsr_pkg::RING_W-1:0] ring_elapsed_next;
  logic                        flag_v;
  logic [acsr_pkg::RING_W-1:0] elapsed_v;

  always_comb begin
    flag_v    = ring_flag;
    elapsed_v = ring_elapsed;
    if (alarm.enabled && tick.time_valid) begin
      if (tick.now_hour == alarm.hour && tick.now_minute == alarm.minute && !flag_v) begin
        flag_v    = 1'b1;
        elapsed_v = '0;
      end
      if (flag_v && (elapsed_v >= ring_duration_ticks || tick.stop_button_down)) begin
        flag_v = 1'b0;
      end
      if (tick.now_hour != alarm.hour) begin
        flag_v = 1'b0;
      end
    end
    if (flag_v && elapsed_v != acsr_pkg::RING_MAX) begin
      elapsed_v = elapsed_v + acsr_pkg::RING_W'(1);
    end
    ringing_next      = flag_v;
    ring_elapsed_next = elapsed_v;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ring_flag    <= 1'b0;
      ring_elapsed <= '0;
    end else if (en) begin
      ring_flag    <= ringing_next;
      ring_elapsed <= ring_elapsed_next;
    end
  end

  `ACSR_ASSERT_SAME(a_ring_starts_at_one, clk, rst, $rose(ring_flag), ring_elapsed == acsr_pkg::RING_W'(1))

endmodule

FILE: design/acsr_edit.sv
// set button timing, draft editing and stored alarm time
`include "alarm_clock_set_and_ring_defines.svh"

module acsr_edit (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             en,
  input  logic                             set_down,
  input  logic                             ring_active,
  input  logic [acsr_pkg::HOLD_W-1:0]      long_press_ticks,
  output acsr_pkg::alarm_t                 stored,
  output acsr_pkg::alarm_t                 stored_next,
  output acsr_pkg::draft_t                 draft_next
);

  acsr_pkg::draft_t            draft;
  logic                        press_held;
  logic                        press_held_next;
  logic                        long_seen;
  logic                        long_seen_next;
  logic [acsr_pkg::HOLD_W-1:0] hold_ticks;
  logic [acsr_pkg::HOLD_W-1:0] hold_ticks_next;

  always_comb begin
    press_held_next = press_held;
    long_seen_next  = long_seen;
    hold_ticks_next = hold_ticks;
    draft_next      = draft;
    stored_next     = stored;
    if (!ring_active) begin
      if (set_down && !press_held) begin
        press_held_next = 1'b1;
        hold_ticks_next = '0;
        long_seen_next  = 1'b0;
      end
      // long press
      if (set_down && !long_seen_next && hold_ticks_next >= long_press_ticks) begin
        long_seen_next = 1'b1;
        if (draft.mode) begin
          draft_next.field = acsr_pkg::field_t'(draft.field + 2'd1);
        end else begin
          draft_next.mode    = 1'b1;
          draft_next.field   = acsr_pkg::FIELD_HOUR;
          draft_next.hour    = stored.hour;
          draft_next.minute  = stored.minute;
          draft_next.enabled = stored.enabled;
        end
      end
      // release, short press
      if (!set_down && press_held) begin
        if (hold_ticks_next < long_press_ticks && !long_seen_next && draft.mode) begin
          unique case (draft.field)
            acsr_pkg::FIELD_HOUR: begin
              draft_next.hour = (draft.hour >= acsr_pkg::LAST_HOUR) ? '0
                                : draft.hour + acsr_pkg::HOUR_W'(1);
            end
            acsr_pkg::FIELD_MINUTE: begin
              draft_next.minute = (draft.minute >= acsr_pkg::LAST_MINUTE) ? '0
                                  : draft.minute + acsr_pkg::MINUTE_W'(1);
            end
            acsr_pkg::FIELD_ON: begin
              draft_next.enabled = !draft.enabled;
            end
            acsr_pkg::FIELD_SAVE: begin
              stored_next.hour    = draft.hour;
              stored_next.minute  = draft.minute;
              stored_next.enabled = draft.enabled;
              draft_next.mode     = 1'b0;
            end
            default: begin
              draft_next = draft;
            end
          endcase
        end
        press_held_next = 1'b0;
      end
    end
    if (press_held_next && hold_ticks_next != acsr_pkg::HOLD_MAX) begin
      hold_ticks_next = hold_ticks_next + acsr_pkg::HOLD_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      press_held     <= 1'b0;
      long_seen      <= 1'b0;
      hold_ticks     <= '0;
      draft.mode     <= 1'b0;
      draft.field    <= acsr_pkg::FIELD_HOUR;
      draft.hour     <= acsr_pkg::ALARM_HOUR_RESET;
      draft.minute   <= acsr_pkg::ALARM_MINUTE_RESET;
      draft.enabled  <= acsr_pkg::ALARM_ON_RESET;
      stored.hour    <= acsr_pkg::ALARM_HOUR_RESET;
      stored.minute  <= acsr_pkg::ALARM_MINUTE_RESET;
      stored.enabled <= acsr_pkg::ALARM_ON_RESET;
    end else if (en) begin
      press_held <= press_held_next;
      long_seen  <= long_seen_next;
      hold_ticks <= hold_ticks_next;
      draft      <= draft_next;
      stored     <= stored_next;
    end
  end

  `ACSR_ASSERT_SAME(a_stored_in_range, clk, rst, 1'b1, stored.hour < acsr_pkg::HOURS_PER_DAY && stored.minute < acsr_pkg::MINUTES_PER_HOUR)
  `ACSR_ASSERT_SAME(a_draft_in_range, clk, rst, 1'b1, draft.hour < acsr_pkg::HOURS_PER_DAY && draft.minute < acsr_pkg::MINUTES_PER_HOUR)
  `ACSR_ASSERT_NEXT(a_ring_freezes_edit, clk, rst, en && ring_active, $stable(draft) && $stable(stored))

endmodule

FILE: design/alarm_clock_set_and_ring.sv
// top level of the alarm clock set and ring block
//
//   channel  direction  handshake                      payload
//   tick     in         tick_valid / tick_ready        tick   (acsr_pkg::in_t)
//   result   out        result_valid / result_ready    result (acsr_pkg::out_t)
//   cfg      in         cfg_we, no wait                cfg_index, cfg_data
//
// one request per cycle while result_ready keeps up; an accepted request is
// held in the request register, which feeds the ring and edit logic; these
// update the state and load the result register in the same cycle
// a stalled result register holds the request register, so tick_ready drops
// rst is synchronous; it clears the handshake and the alarm state and reloads
// the config defaults; tick_ready is low while rst is high

`include "alarm_clock_set_and_ring_defines.svh"

module alarm_clock_set_and_ring (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                tick_valid,
  output logic                                tick_ready,
  input  acsr_pkg::in_t                       tick,
  output logic                                result_valid,
  input  logic                                result_ready,
  output acsr_pkg::out_t                      result,
  input  logic                                cfg_we,
  input  acsr_pkg::cfg_reg_t                  cfg_index,
  input  logic [acsr_pkg::CFG_DATA_W-1:0]     cfg_data
);

  logic                            stage_valid;
  acsr_pkg::in_t                   stage;
  logic                            advance;
  logic [acsr_pkg::HOLD_W-1:0]     long_press_ticks;
  logic [acsr_pkg::RING_W-1:0]     ring_duration_ticks;
  logic                            ringing_next;
  acsr_pkg::alarm_t                stored;
  acsr_pkg::alarm_t                stored_next;
  acsr_pkg::draft_t                draft_next;

  assign advance    = stage_valid && (!result_valid || result_ready);
  assign tick_ready = !rst && (!stage_valid || advance);

  always_ff @(posedge clk) begin
    if (rst) begin
      long_press_ticks    <= acsr_pkg::LONG_PRESS_RESET;
      ring_duration_ticks <= acsr_pkg::RING_DURATION_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        acsr_pkg::CFG_LONG_PRESS:    long_press_ticks    <= cfg_data[acsr_pkg::HOLD_W-1:0];
        acsr_pkg::CFG_RING_DURATION: ring_duration_ticks <= cfg_data[acsr_pkg::RING_W-1:0];
        default: begin
          long_press_ticks <= long_press_ticks;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (tick_ready) begin
      stage_valid <= tick_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (tick_valid && tick_ready) begin
      stage <= tick;
    end
  end

  acsr_ring u_ring (
    .clk                 (clk),
    .rst                 (rst),
    .en                  (advance),
    .tick                (stage),
    .alarm               (stored),
    .ring_duration_ticks (ring_duration_ticks),
    .ringing_next        (ringing_next)
  );

  acsr_edit u_edit (
    .clk              (clk),
    .rst              (rst),
    .en               (advance),
    .set_down         (stage.set_button_down),
    .ring_active      (ringing_next),
    .long_press_ticks (long_press_ticks),
    .stored           (stored),
    .stored_next      (stored_next),
    .draft_next       (draft_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result.ringing        <= ringing_next;
      result.setting_active <= draft_next.mode;
      result.selected_field <= draft_next.field;
      result.draft_hour     <= draft_next.hour;
      result.draft_minute   <= draft_next.minute;
      result.draft_on       <= draft_next.enabled;
      result.saved_hour     <= stored_next.hour;
      result.saved_minute   <= stored_next.minute;
      result.saved_on       <= stored_next.enabled;
    end
  end

  `ACSR_ASSERT_NEXT(a_advance_loads_result, clk, rst, advance, result_valid)
  `ACSR_ASSERT_SAME(a_stall_blocks_request, clk, rst, stage_valid && result_valid && !result_ready, !tick_ready)

endmodule
